[rtl/scpt_pkg.sv]
package scpt_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 65536;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CP_W        = 21;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // Request kinds
  localparam logic REQ_UPSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    STAT_FOUND     = 2'd0,
    STAT_INSERTED  = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [CP_W-1:0] code;
    logic [CP_W-1:0] upper;
    logic [CP_W-1:0] lower;
    logic [CP_W-1:0] title;
  } entry_t;

  typedef struct packed {
    logic            req_type;
    logic [CP_W-1:0] code;
    logic            upper_valid;
    logic [CP_W-1:0] upper_value;
    logic            lower_valid;
    logic [CP_W-1:0] lower_value;
    logic            title_valid;
    logic [CP_W-1:0] title_value;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [CP_W-1:0]  key_echo;
    logic [CP_W-1:0]  upper_out;
    logic [CP_W-1:0]  lower_out;
    logic [CP_W-1:0]  title_out;
    logic [CNT_W-1:0] entry_count;
  } res_t;

endpackage

[rtl/scpt_if.sv]
interface scpt_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [scpt_pkg::CP_W-1:0] code;
  logic                      upper_valid;
  logic [scpt_pkg::CP_W-1:0] upper_value;
  logic                      lower_valid;
  logic [scpt_pkg::CP_W-1:0] lower_value;
  logic                      title_valid;
  logic [scpt_pkg::CP_W-1:0] title_value;

  modport source (
    output valid, req_type, code, upper_valid, upper_value,
           lower_valid, lower_value, title_valid, title_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, code, upper_valid, upper_value,
           lower_valid, lower_value, title_valid, title_value,
    output ready
  );
endinterface

interface scpt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [scpt_pkg::CP_W-1:0]  key_echo;
  logic [scpt_pkg::CP_W-1:0]  upper_out;
  logic [scpt_pkg::CP_W-1:0]  lower_out;
  logic [scpt_pkg::CP_W-1:0]  title_out;
  logic [scpt_pkg::CNT_W-1:0] entry_count;

  modport source (
    output valid, status, key_echo, upper_out, lower_out, title_out, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, key_echo, upper_out, lower_out, title_out, entry_count,
    output ready
  );
endinterface

[rtl/scpt_core.sv]
module scpt_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  scpt_pkg::req_t  req_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output scpt_pkg::res_t  res_o
);
  import scpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_SHIFT,
    S_INS,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [CNT_W-1:0]  lo_q, lo_d, hi_q, hi_d, count_q, count_d;
  logic [ADDR_W-1:0] mid_q, mid_d, pos_q, pos_d, shift_q, shift_d;
  logic              found_q, found_d;
  entry_t            ent_q, ent_d;
  res_t              res_q, res_d;

  // Entry store: one write port, one read port, registered read data
  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_data_q;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  entry_t            wr_data;

  logic [CNT_W-1:0]  nlo, nhi, nmid;
  entry_t            merged;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Entry after the request: existing or blank, with flagged mappings applied on upsert
  always_comb begin
    merged = found_q ? ent_q : '0;
    merged.code = req_q.code;
    if (req_q.req_type == REQ_UPSERT) begin
      if (req_q.upper_valid) merged.upper = req_q.upper_value;
      if (req_q.lower_valid) merged.lower = req_q.lower_value;
      if (req_q.title_valid) merged.title = req_q.title_value;
    end
  end

  // Next probe window, descending order
  always_comb begin
    if (rd_data_q.code > req_q.code) begin
      nlo = CNT_W'(mid_q) + CNT_W'(1);
      nhi = hi_q;
    end else begin
      nlo = lo_q;
      nhi = CNT_W'(mid_q);
    end
    nmid = nlo + ((nhi - nlo) >> 1);
  end

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    pos_d   = pos_q;
    shift_d = shift_q;
    found_d = found_q;
    ent_d   = ent_q;
    count_d = count_q;
    res_d   = res_q;
    rd_en   = 1'b0;
    rd_addr = mid_q;
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = merged;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          found_d = 1'b0;
          if (count_q == '0) begin
            pos_d   = '0;
            state_d = S_APPLY;
          end else begin
            lo_d    = '0;
            hi_d    = count_q;
            mid_d   = ADDR_W'(count_q >> 1);
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(count_q >> 1);
            state_d = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        if (rd_data_q.code == req_q.code) begin
          found_d = 1'b1;
          pos_d   = mid_q;
          ent_d   = rd_data_q;
          state_d = S_APPLY;
        end else if (nlo < nhi) begin
          lo_d    = nlo;
          hi_d    = nhi;
          mid_d   = nmid[ADDR_W-1:0];
          rd_en   = 1'b1;
          rd_addr = nmid[ADDR_W-1:0];
        end else begin
          // nlo may equal the depth only when the table is full; pos unused then
          pos_d   = nlo[ADDR_W-1:0];
          state_d = S_APPLY;
        end
      end

      S_APPLY: begin
        res_d.key_echo    = req_q.code;
        res_d.entry_count = count_q;
        res_d.upper_out   = '0;
        res_d.lower_out   = '0;
        res_d.title_out   = '0;
        if (found_q) begin
          wr_en           = (req_q.req_type == REQ_UPSERT);
          res_d.status    = STAT_FOUND;
          res_d.upper_out = merged.upper;
          res_d.lower_out = merged.lower;
          res_d.title_out = merged.title;
          state_d         = S_OUT;
        end else if (req_q.req_type == REQ_LOOKUP) begin
          res_d.status = STAT_NOT_FOUND;
          state_d      = S_OUT;
        end else if (count_q == DEPTH_CNT) begin
          res_d.status = STAT_FULL;
          state_d      = S_OUT;
        end else if (CNT_W'(pos_q) < count_q) begin
          // open a hole: move entries from the top down
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(count_q - CNT_W'(1));
          shift_d = count_q[ADDR_W-1:0];
          state_d = S_SHIFT;
        end else begin
          state_d = S_INS;
        end
      end

      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = shift_q;
        wr_data = rd_data_q;
        if (shift_q - ADDR_W'(1) == pos_q) begin
          state_d = S_INS;
        end else begin
          rd_en   = 1'b1;
          rd_addr = shift_q - ADDR_W'(2);
          shift_d = shift_q - ADDR_W'(1);
        end
      end

      S_INS: begin
        wr_en             = 1'b1;
        count_d           = count_q + CNT_W'(1);
        res_d.status      = STAT_INSERTED;
        res_d.key_echo    = req_q.code;
        res_d.upper_out   = merged.upper;
        res_d.lower_out   = merged.lower;
        res_d.title_out   = merged.title;
        res_d.entry_count = count_q + CNT_W'(1);
        state_d           = S_OUT;
      end

      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    pos_q   <= pos_d;
    shift_q <= shift_d;
    found_q <= found_d;
    ent_q   <= ent_d;
    res_q   <= res_d;
  end

endmodule

[rtl/sorted_code_point_table.sv]
// Channel  Dir  Carries                                   Handshake
// req_i    in   req_type, code, 3 x (valid, value)        valid/ready
// rsp_o    out  status, key_echo, 3 mappings, entry_count valid/ready
//
// Operation: one request at a time. Binary search does one probe per cycle on the
//   entry RAM; an insert first moves every entry at or above the insert position
//   up by one place, starting from the top.
// Reset: clears the state machine and entry count; the RAM is never cleared.
// Stalls: a finished response waits in the output register while the next
//   request is taken and searched.
module sorted_code_point_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  scpt_req_if.sink          req_i,
  scpt_rsp_if.source        rsp_o
);
  import scpt_pkg::*;

  req_t  core_req;
  res_t  core_res;
  logic  core_res_valid;
  logic  core_res_ready;

  // Output register
  logic  out_valid_q;
  res_t  out_q;

  // Pack the request transaction for the core
  always_comb begin
    core_req.req_type    = req_i.req_type;
    core_req.code        = req_i.code;
    core_req.upper_valid = req_i.upper_valid;
    core_req.upper_value = req_i.upper_value;
    core_req.lower_valid = req_i.lower_valid;
    core_req.lower_value = req_i.lower_value;
    core_req.title_valid = req_i.title_valid;
    core_req.title_value = req_i.title_value;
  end

  scpt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (core_req),
    .res_valid_o (core_res_valid),
    .res_ready_i (core_res_ready),
    .res_o       (core_res)
  );

  // Core may hand over a response when the register is empty or draining
  assign core_res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_res_ready) begin
      out_valid_q <= core_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res_ready && core_res_valid) begin
      out_q <= core_res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.key_echo    = out_q.key_echo;
  assign rsp_o.upper_out   = out_q.upper_out;
  assign rsp_o.lower_out   = out_q.lower_out;
  assign rsp_o.title_out   = out_q.title_out;
  assign rsp_o.entry_count = out_q.entry_count;

endmodule
